### rtl/dcp_pkg.sv
// Package for the distinct colour probe: shared constants, widths and types.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dcp_pkg;

	// Widths of the stream fields and configuration registers.
	localparam int PIX_W   = 16;
	localparam int DIM_W   = 13;
	localparam int CNT_W   = 6;
	// A frame holds up to MAX_DIM * MAX_DIM pixels, which needs 25 bits.
	localparam int POS_W   = 25;

	localparam int PROBE_LIMIT = 48;
	localparam int SET_SIZE    = 40;
	localparam int MAX_DIM     = 4096;
	localparam int SMALL_FRAME = 16;
	localparam int SET_IDX_W   = $clog2(SET_SIZE);

	// The step is n / 48, taken as (n >> 4) / 3. Division by three uses the
	// reciprocal ceil(2^21 / 3), exact for every dividend below 2^21.
	localparam int SCALE_SHIFT = 4;
	localparam int QUOT_IN_W   = POS_W - SCALE_SHIFT;
	localparam int DIV3_SHIFT  = 21;
	localparam int DIV3_MUL_W  = 20;
	localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 20'd699051;
	localparam int PROD_W      = QUOT_IN_W + DIV3_MUL_W;

	// Configuration register indexes.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Controller states: three steps of size arithmetic, then streaming.
	typedef enum logic [1:0] {
		ST_MUL,
		ST_SCALE,
		ST_STEP,
		ST_RUN
	} dcp_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic calc_mul;
		logic calc_scale;
		logic calc_step;
		logic take_pixel;
	} dcp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_full;
	} dcp_status_t;

endpackage
`default_nettype wire

### rtl/dcp_ctrl.sv
// Controller of the distinct colour probe: sequences size arithmetic and
// gates pixel acceptance. Depends on dcp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dcp_ctrl
	import dcp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic        pix_valid,
	output logic             pix_ready,
	input  wire dcp_status_t status,
	output dcp_cmd_t         cmd
);

	dcp_state_t state_q;
	dcp_state_t state_next;

	// State register; after reset the frame size is worked out first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MUL;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands. Any register write restarts the size arithmetic.
	always_comb begin
		state_next     = state_q;
		cmd            = '0;
		pix_ready      = 1'b0;
		unique case (state_q)
			ST_MUL: begin
				cmd.calc_mul = 1'b1;
				state_next   = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.calc_scale = 1'b1;
				state_next     = ST_STEP;
			end
			ST_STEP: begin
				cmd.calc_step = 1'b1;
				state_next    = ST_RUN;
			end
			ST_RUN: begin
				pix_ready      = !status.out_full;
				cmd.take_pixel = pix_valid && pix_ready;
			end
			default: begin
				state_next = ST_MUL;
			end
		endcase
		if (cfg_write) begin
			state_next = ST_MUL;
		end
	end

endmodule
`default_nettype wire

### rtl/dcp_datapath.sv
// Datapath of the distinct colour probe: size registers and arithmetic,
// frame counters, the 40-entry value set and the result register.
// Depends on dcp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dcp_datapath
	import dcp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write,
	input  wire logic             cfg_index,
	input  wire logic [DIM_W-1:0] cfg_data,
	input  wire dcp_cmd_t         cmd,
	output dcp_status_t           status,
	input  wire logic [PIX_W-1:0] pixel_value,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  frame_noisy,
	output logic [CNT_W-1:0]      distinct_samples
);

	localparam logic [DIM_W-1:0] DimMax = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0]     width_q;
	logic [DIM_W-1:0]     height_q;
	logic [DIM_W-1:0]     width_c;
	logic [DIM_W-1:0]     height_c;
	logic [POS_W-1:0]     pixels_q;
	logic [PROD_W-1:0]    prod_q;
	logic [POS_W-1:0]     step_q;
	logic                 small_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     next_q;
	logic [CNT_W-1:0]     probes_q;
	logic [CNT_W-1:0]     seen_q;
	logic [PIX_W-1:0]     set_q [SET_SIZE];
	logic [SET_SIZE-1:0]  match;
	logic                 hit;
	logic                 sample;
	logic                 insert;
	logic                 last;
	logic [CNT_W-1:0]     seen_next;
	logic [POS_W-1:0]     quot;
	logic                 out_valid_q;
	logic                 noisy_q;
	logic [CNT_W-1:0]     count_q;

	// Configuration registers; both reset to one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_write) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == REG_FRAME_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// Dimensions are clamped into one to MAX_DIM.
	always_comb begin
		width_c  = (width_q == '0) ? DIM_W'(1) : ((width_q > DimMax) ? DimMax : width_q);
		height_c = (height_q == '0) ? DIM_W'(1) : ((height_q > DimMax) ? DimMax : height_q);
	end

	assign quot = POS_W'(prod_q[PROD_W-1:DIV3_SHIFT]);

	// Size arithmetic: pixel count, scaled reciprocal product, then the step.
	always_ff @(posedge clk) begin
		if (cmd.calc_mul) begin
			pixels_q <= POS_W'({{DIM_W{1'b0}}, width_c} * {{DIM_W{1'b0}}, height_c});
		end
		if (cmd.calc_scale) begin
			prod_q <= PROD_W'(pixels_q[POS_W-1:SCALE_SHIFT]) * PROD_W'(DIV3_MUL);
		end
		if (cmd.calc_step) begin
			step_q  <= (quot == '0) ? POS_W'(1) : quot;
			small_q <= pixels_q < POS_W'(SMALL_FRAME);
		end
	end

	// Parallel compare of the pixel against the filled part of the set.
	always_comb begin
		for (int j = 0; j < SET_SIZE; j++) begin
			match[j] = (CNT_W'(j) < seen_q) && (set_q[j] == pixel_value);
		end
	end

	assign hit       = |match;
	assign sample    = !small_q && (pos_q == next_q) && (probes_q < CNT_W'(PROBE_LIMIT));
	assign insert    = sample && !hit && (seen_q < CNT_W'(SET_SIZE));
	assign seen_next = insert ? seen_q + CNT_W'(1) : seen_q;
	assign last      = ({1'b0, pos_q} + (POS_W + 1)'(1)) >= {1'b0, pixels_q};

	// Frame counters; all of them return to zero after the last pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			next_q   <= '0;
			probes_q <= '0;
			seen_q   <= '0;
		end else if (cmd.take_pixel) begin
			if (last) begin
				pos_q    <= '0;
				next_q   <= '0;
				probes_q <= '0;
				seen_q   <= '0;
			end else begin
				pos_q  <= pos_q + POS_W'(1);
				seen_q <= seen_next;
				if (sample) begin
					probes_q <= probes_q + CNT_W'(1);
					next_q   <= next_q + step_q;
				end
			end
		end
	end

	// Set storage, written at the fill position.
	always_ff @(posedge clk) begin
		if (cmd.take_pixel && insert) begin
			set_q[SET_IDX_W'(seen_q)] <= pixel_value;
		end
	end

	// Result register, filled on the last pixel and emptied by the sink.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.take_pixel && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_pixel && last) begin
			noisy_q <= !small_q && (seen_next >= CNT_W'(SET_SIZE));
			count_q <= small_q ? '0 : seen_next;
		end
	end

	assign status.out_full  = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign frame_noisy      = noisy_q;
	assign distinct_samples = count_q;

endmodule
`default_nettype wire

### rtl/distinct_color_probe.sv
// Top level of the distinct colour probe: joins controller and datapath.
// Depends on dcp_pkg, dcp_ctrl and dcp_datapath.
//
//   Channel   Direction  Handshake                    Content
//   s_axis    in         s_axis_tvalid/s_axis_tready  one RGB565 pixel
//   m_axis    out        m_axis_tvalid/m_axis_tready  noisy flag and count
//   cfg       in         cfg_valid/cfg_ready          register index and value
//
// One pixel is taken per cycle while streaming and no held result waits for the
// sink; the result is written as the last pixel is taken. The result register
// takes one frame result; a new pixel waits while a result is held and not taken.
// After reset and after every register write, the size arithmetic (multiply,
// reciprocal multiply, step) runs, and no pixel is taken until it is done.
// Reset empties the counters, so the first pixel after it starts a frame.
`timescale 1ns / 1ps
`default_nettype none
module distinct_color_probe
	import dcp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [PIX_W-1:0] s_axis_tdata,   // [15:0] pixel_value
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [7:0]            m_axis_tdata,   // [0] frame_noisy, [6:1] distinct_samples
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [DIM_W-1:0] cfg_data
);

	dcp_cmd_t         cmd;
	dcp_status_t      status;
	logic             cfg_write;
	logic             noisy;
	logic [CNT_W-1:0] count;

	// Configuration transactions are always taken.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	dcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.pix_valid (s_axis_tvalid),
		.pix_ready (s_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	dcp_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.status           (status),
		.pixel_value      (s_axis_tdata),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.frame_noisy      (noisy),
		.distinct_samples (count)
	);

	// Output fields packed from the lowest bit, padded to a byte.
	assign m_axis_tdata = {1'b0, count, noisy};

endmodule
`default_nettype wire
